// ===== design/sacl_pkg.sv =====
// ============================================================================
// sacl_pkg: shared definitions for the set-associative cache LRU model
// Defaults, register indexes, access codes and the way-logic outcome record.
// ============================================================================
package sacl_pkg;

    // Default sizes of the tag store.
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int WAYS_DEF         = 4;
    localparam int ADDR_WIDTH_DEF   = 64;

    // Running totals saturate at this width.
    localparam int TOTAL_W = 32;

    // Stream widths.
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 104;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    localparam logic [2:0] SET_BITS_RST   = 3'd0;
    localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [2:0] WAYS_USED_RST  = 3'd1;

    // Access kinds.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_STORE,
        OP_MODIFY,
        OP_IFETCH
    } op_t;

    // What the way logic decided for one access.
    typedef struct packed {
        logic [1:0] hit_count;
        logic       missed;
        logic       evicted;
        logic       wr_en;
    } outcome_t;

endpackage

// ===== design/sacl_cfg.sv =====
// ============================================================================
// sacl_cfg: configuration registers
// Holds set_bits, block_bits and ways_used; set_bits and ways_used are
// presented clamped to the ranges the tag store supports.
// ============================================================================
module sacl_cfg #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int WAYS         = sacl_pkg::WAYS_DEF,
    parameter int WCNT_W       = $clog2(sacl_pkg::WAYS_DEF + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [2:0]                       set_sel,
    output logic [5:0]                       block_bits,
    output logic [WCNT_W-1:0]                ways_n
);
    import sacl_pkg::*;

    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [2:0] ways_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_used_reg  <= WAYS_USED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[5:0];
                CFG_WAYS_USED:  ways_used_reg  <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // A set count above the store's depth falls back to the largest one.
    assign set_sel = (int'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;

    assign block_bits = block_bits_reg;

    // Zero ways means one; more than the store has means all of them.
    always_comb
    begin
        if (ways_used_reg == 3'd0)
            ways_n = WCNT_W'(1);
        else if (int'(ways_used_reg) > WAYS)
            ways_n = WCNT_W'(WAYS);
        else
            ways_n = WCNT_W'(ways_used_reg);
    end

endmodule

// ===== design/sacl_store.sv =====
// ============================================================================
// sacl_store: per-set state and tag memories
// One row per set holds the valid bits, LRU ages and tags of all ways. Reads
// are registered; a row written at the same edge is forwarded to the reader.
// ============================================================================
module sacl_store #(
    parameter int ROWS       = 64,
    parameter int SET_IDX_W  = 6,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int AGE_W      = 2,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [SET_IDX_W-1:0]       rd_set,
    input  logic                       wr_en,
    input  logic [SET_IDX_W-1:0]       wr_set,
    input  logic [WAYS-1:0]            wr_valid,
    input  logic [WAYS*AGE_W-1:0]      wr_age,
    input  logic [WAYS*ADDR_WIDTH-1:0] wr_tag,
    output logic [WAYS-1:0]            rd_valid,
    output logic [WAYS*AGE_W-1:0]      rd_age,
    output logic [WAYS*ADDR_WIDTH-1:0] rd_tag
);
    import sacl_pkg::*;

    localparam int ST_W      = WAYS * (1 + AGE_W);
    localparam int TAG_ROW_W = WAYS * ADDR_WIDTH;

    logic [ST_W-1:0]      state_mem [ROWS];
    logic [TAG_ROW_W-1:0] tag_mem   [ROWS];

    logic [ROWS-1:0]      row_ok_reg;
    logic                 ok_rd_reg;
    logic                 fwd_reg;
    logic [ST_W-1:0]      state_rd_reg;
    logic [ST_W-1:0]      fwd_state_reg;
    logic [TAG_ROW_W-1:0] tag_rd_reg;
    logic [TAG_ROW_W-1:0] fwd_tag_reg;
    logic [ST_W-1:0]      wr_state;
    logic [ST_W-1:0]      row_state;

    assign wr_state = {wr_age, wr_valid};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_set] <= wr_state;
            tag_mem[wr_set]   <= wr_tag;
        end
        if (rd_en)
        begin
            state_rd_reg  <= state_mem[rd_set];
            tag_rd_reg    <= tag_mem[rd_set];
            fwd_state_reg <= wr_state;
            fwd_tag_reg   <= wr_tag;
        end
    end

    // A row that was never written reads as all ways invalid with age zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            ok_rd_reg  <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_ok_reg[wr_set] <= 1'b1;
            if (rd_en)
            begin
                ok_rd_reg <= row_ok_reg[rd_set];
                fwd_reg   <= wr_en && (wr_set == rd_set);
            end
        end
    end

    assign row_state = fwd_reg   ? fwd_state_reg :
                       ok_rd_reg ? state_rd_reg  : '0;
    assign rd_valid  = row_state[WAYS-1:0];
    assign rd_age    = row_state[ST_W-1:WAYS];
    assign rd_tag    = fwd_reg ? fwd_tag_reg : tag_rd_reg;

endmodule

// ===== design/sacl_lookup.sv =====
// ============================================================================
// sacl_lookup: way compare and LRU update
// Compares all in-use ways of one set at once, picks the hit, free or victim
// way, and builds the row to write back.
// ============================================================================
module sacl_lookup #(
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int AGE_W      = 2,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF,
    parameter int WCNT_W     = $clog2(sacl_pkg::WAYS_DEF + 1)
) (
    input  sacl_pkg::op_t                op,
    input  logic [ADDR_WIDTH-1:0]        tag,
    input  logic [WCNT_W-1:0]            ways_n,
    input  logic [WAYS-1:0]              row_valid,
    input  logic [WAYS*AGE_W-1:0]        row_age,
    input  logic [WAYS*ADDR_WIDTH-1:0]   row_tag,
    output sacl_pkg::outcome_t           res,
    output logic [WAYS-1:0]              new_valid,
    output logic [WAYS*AGE_W-1:0]        new_age,
    output logic [WAYS*ADDR_WIDTH-1:0]   new_tag
);
    import sacl_pkg::*;

    localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

    logic [AGE_W-1:0]      age  [WAYS];
    logic [ADDR_WIDTH-1:0] tags [WAYS];
    logic [WAYS-1:0]       in_use;
    logic [WAYS-1:0]       match;
    logic [WAYS-1:0]       free;
    logic                  found;
    logic                  have_free;
    logic [WIDX_W-1:0]     hit_way;
    logic [WIDX_W-1:0]     free_way;
    logic [WIDX_W-1:0]     victim;
    logic [WIDX_W-1:0]     w;
    logic [AGE_W-1:0]      old_age;
    logic                  active;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            age[i]    = row_age[i*AGE_W +: AGE_W];
            tags[i]   = row_tag[i*ADDR_WIDTH +: ADDR_WIDTH];
            in_use[i] = int'(ways_n) > i;
            match[i]  = in_use[i] && row_valid[i] && (tags[i] == tag);
            free[i]   = in_use[i] && !row_valid[i];
        end
    end

    // Lowest-numbered hit and free way; victim is the oldest valid way,
    // the lowest index winning a tie.
    always_comb
    begin
        found     = |match;
        have_free = |free;
        hit_way   = '0;
        free_way  = '0;
        victim    = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_way = WIDX_W'(i);
            if (free[i])
                free_way = WIDX_W'(i);
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (in_use[i] && row_valid[i] && (age[i] > age[victim]))
                victim = WIDX_W'(i);
        end
    end

    always_comb
    begin
        active = (op != OP_IFETCH);
        if (found)
        begin
            w       = hit_way;
            old_age = age[hit_way];
        end
        else if (have_free)
        begin
            // A fresh fill ages everything younger than the oldest possible age.
            w       = free_way;
            old_age = AGE_MAX;
        end
        else
        begin
            w       = victim;
            old_age = age[victim];
        end

        new_valid = row_valid;
        new_tag   = row_tag;
        for (int i = 0; i < WAYS; i++)
        begin
            // An age below old_age is below AGE_MAX, so the increment cannot wrap.
            if (WIDX_W'(i) == w)
                new_age[i*AGE_W +: AGE_W] = '0;
            else if (in_use[i] && row_valid[i] && (age[i] < old_age))
                new_age[i*AGE_W +: AGE_W] = age[i] + AGE_W'(1);
            else
                new_age[i*AGE_W +: AGE_W] = age[i];
        end
        if (!found)
        begin
            new_valid[w]                       = 1'b1;
            new_tag[w*ADDR_WIDTH +: ADDR_WIDTH] = tag;
        end

        res.wr_en     = active;
        res.missed    = active && !found;
        res.evicted   = active && !found && !have_free;
        res.hit_count = active ? (2'(found) + 2'(op == OP_MODIFY)) : 2'd0;
    end

endmodule

// ===== design/set_assoc_cache_lru_model.sv =====
// ============================================================================
// set_assoc_cache_lru_model: set-associative cache tag store with true LRU
// Takes a stream of memory accesses and reports hits, misses, evictions and
// saturating running totals for each one.
// ============================================================================
// Usage
//   Input items arrive on s_tvalid/s_tready: s_tuser carries the access kind
//   (load, store, modify, instruction fetch) and s_tdata the byte address.
//   Each accepted item gives exactly one result item on m_tvalid/m_tready.
//   Configuration (set_bits, block_bits, ways_used) is written through
//   cfg_we/cfg_index/cfg_data while no item is in flight.
// Pipeline and throughput
//   An accepted item passes through the lookup stage registers and then the
//   output register before its result is presented on m_tvalid. One item is
//   taken per cycle while the output is not stalled:
//   the set row is read from memory on acceptance, and the way compare and
//   LRU update run in the lookup stage, writing the row back as it moves on. A row
//   written at the same edge as the next read is forwarded, so accesses to
//   the same set may follow each other back to back.
// Reset
//   rst_n clears the pipeline, totals, configuration and the per-set valid
//   flags; every set then reads as empty. No clearing pass is needed.
// Stalls
//   While m_tready is low the result waits in the output register, one more
//   item may be accepted into the lookup stage, and then s_tready drops.
// ============================================================================
module set_assoc_cache_lru_model #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int WAYS         = sacl_pkg::WAYS_DEF,
    parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // address[63:0]
    input  logic [sacl_pkg::IN_DATA_W-1:0]    s_tdata,
    // op[1:0]
    input  logic [sacl_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_count[1:0], missed[2], evicted[3], hit_tally[35:4],
    // miss_tally[67:36], evict_tally[99:68], zero fill[103:100]
    output logic [sacl_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sacl_pkg::*;

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS      = 1 << MAX_SET_BITS;
    localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W    = $clog2(WAYS + 1);

    // Configuration.
    logic [2:0]        set_sel;
    logic [5:0]        block_bits;
    logic [WCNT_W-1:0] ways_n;

    sacl_cfg #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .WCNT_W       (WCNT_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .set_sel    (set_sel),
        .block_bits (block_bits),
        .ways_n     (ways_n)
    );

    // Address split at the input: set index selects the row to read, the
    // rest above it is the tag. A shift past the address width gives zero.
    logic [ADDR_WIDTH-1:0] addr_in;
    logic [6:0]            tag_shift;
    logic [SET_IDX_W-1:0]  set_mask;
    logic [SET_IDX_W-1:0]  set_in;
    logic [ADDR_WIDTH-1:0] tag_in;
    logic                  accept;

    assign addr_in   = s_tdata[ADDR_WIDTH-1:0];
    assign tag_shift = 7'(set_sel) + 7'(block_bits);
    assign set_mask  = ~({SET_IDX_W{1'b1}} << set_sel);
    assign set_in    = SET_IDX_W'(addr_in >> block_bits) & set_mask;
    assign tag_in    = addr_in >> tag_shift;
    assign accept    = s_tvalid && s_tready;

    // Lookup stage registers.
    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    logic [SET_IDX_W-1:0]  s1_set_reg;
    logic [ADDR_WIDTH-1:0] s1_tag_reg;
    logic                  s1_go;

    // Output register and totals.
    logic                  m_valid_reg;
    logic [1:0]            hit_count_reg;
    logic                  missed_reg;
    logic                  evicted_reg;
    logic [TOTAL_W-1:0]    hit_tally_reg;
    logic [TOTAL_W-1:0]    miss_tally_reg;
    logic [TOTAL_W-1:0]    evict_tally_reg;
    logic [TOTAL_W-1:0]    hit_tally_next;
    logic [TOTAL_W-1:0]    miss_tally_next;
    logic [TOTAL_W-1:0]    evict_tally_next;

    // The lookup stage moves on when the output register is empty or drains.
    assign s1_go    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= op_t'(s_tuser);
            s1_set_reg <= set_in;
            s1_tag_reg <= tag_in;
        end
    end

    // Set rows.
    logic [WAYS-1:0]            row_valid;
    logic [WAYS*AGE_W-1:0]      row_age;
    logic [WAYS*ADDR_WIDTH-1:0] row_tag;
    logic [WAYS-1:0]            new_valid;
    logic [WAYS*AGE_W-1:0]      new_age;
    logic [WAYS*ADDR_WIDTH-1:0] new_tag;
    outcome_t                   res;

    sacl_store #(
        .ROWS       (ROWS),
        .SET_IDX_W  (SET_IDX_W),
        .WAYS       (WAYS),
        .AGE_W      (AGE_W),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_set   (set_in),
        .wr_en    (s1_go && res.wr_en),
        .wr_set   (s1_set_reg),
        .wr_valid (new_valid),
        .wr_age   (new_age),
        .wr_tag   (new_tag),
        .rd_valid (row_valid),
        .rd_age   (row_age),
        .rd_tag   (row_tag)
    );

    sacl_lookup #(
        .WAYS       (WAYS),
        .AGE_W      (AGE_W),
        .ADDR_WIDTH (ADDR_WIDTH),
        .WCNT_W     (WCNT_W)
    ) u_lookup (
        .op        (s1_op_reg),
        .tag       (s1_tag_reg),
        .ways_n    (ways_n),
        .row_valid (row_valid),
        .row_age   (row_age),
        .row_tag   (row_tag),
        .res       (res),
        .new_valid (new_valid),
        .new_age   (new_age),
        .new_tag   (new_tag)
    );

    // Saturating totals. A carry out of the 33-bit sum pins the total at its top.
    logic [TOTAL_W:0] hit_sum;
    logic [TOTAL_W:0] miss_sum;
    logic [TOTAL_W:0] evict_sum;

    always_comb
    begin
        hit_sum          = {1'b0, hit_tally_reg} + (TOTAL_W + 1)'(res.hit_count);
        miss_sum         = {1'b0, miss_tally_reg} + (TOTAL_W + 1)'(res.missed);
        evict_sum        = {1'b0, evict_tally_reg} + (TOTAL_W + 1)'(res.evicted);
        hit_tally_next   = hit_sum[TOTAL_W]   ? '1 : hit_sum[TOTAL_W-1:0];
        miss_tally_next  = miss_sum[TOTAL_W]  ? '1 : miss_sum[TOTAL_W-1:0];
        evict_tally_next = evict_sum[TOTAL_W] ? '1 : evict_sum[TOTAL_W-1:0];
    end

    // Totals only change when a new result enters the output register, so
    // the output can show them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg     <= 1'b0;
            hit_tally_reg   <= '0;
            miss_tally_reg  <= '0;
            evict_tally_reg <= '0;
        end
        else
        begin
            if (s1_go)
            begin
                m_valid_reg     <= 1'b1;
                hit_tally_reg   <= hit_tally_next;
                miss_tally_reg  <= miss_tally_next;
                evict_tally_reg <= evict_tally_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            hit_count_reg <= res.hit_count;
            missed_reg    <= res.missed;
            evicted_reg   <= res.evicted;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, evict_tally_reg, miss_tally_reg, hit_tally_reg,
                       evicted_reg, missed_reg, hit_count_reg};

    // The input side only backs up when both stages hold items and the
    // receiver is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled while a stage could move");

    // Totals never go backwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hit_tally_reg >= $past(hit_tally_reg))
                 && (miss_tally_reg >= $past(miss_tally_reg))
                 && (evict_tally_reg >= $past(evict_tally_reg)))
        else $error("running total decreased");

    // An eviction only happens on a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && evicted_reg) |-> missed_reg)
        else $error("eviction reported without a miss");

    // A miss leaves at most the second hit of a modify.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && missed_reg) |-> (hit_count_reg != 2'd2) && (hit_count_reg != 2'd3))
        else $error("miss reported together with a lookup hit");

endmodule
